FILE: hw/rtl/s2cd_pkg.sv
// Shared constants, types and calendar helper functions for the seconds-to-date converter.
`timescale 1ns / 1ps
`default_nettype none

package s2cd_pkg;

   // Default width of the seconds count that is actually used.
   localparam int COUNT_WIDTH_DEF = 32;

   // Width of the remainder register in the day divider; it holds values below 86400.
   localparam int DAY_REM_W = 17;

   // Width of the remainder register in the time-of-day divider; it holds values below 3600.
   localparam int TOD_REM_W = 12;

   // Width of the year offset from the epoch year.
   localparam int YN_W = 9;

   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [16:0] DAYS_LEAP_YEAR = 17'd366;
   localparam logic [16:0] DAYS_YEAR      = 17'd365;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [11:0] SECS_PER_MIN   = 12'd60;
   localparam logic [11:0] EPOCH_YEAR     = 12'd2000;

   // Cumulative day counts at the start of each month, normal and leap years.
   localparam logic [8:0] CUM_NORM [13] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                            9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
                                            9'd334, 9'd365};
   localparam logic [8:0] CUM_LEAP [13] = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
                                            9'd182, 9'd213, 9'd244, 9'd274, 9'd305,
                                            9'd335, 9'd366};

   // Control word for a bit-serial divider.
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // Leap rule for year 2000+n; the epoch year is a multiple of 400 and n stays below 400.
   function automatic logic is_leap(input logic [YN_W-1:0] n);
      logic century;
      begin
         century = (n == 9'd100) || (n == 9'd200) || (n == 9'd300);
         is_leap = (n[1:0] == 2'b00) && !century;
      end
   endfunction

   // Days from the epoch to the first day of year 2000+n.
   function automatic logic [16:0] days_before(input logic [7:0] n);
      logic [16:0] base;
      logic [8:0]  quads;
      logic [1:0]  cents;
      logic        quad_cents;
      begin
         base  = 17'(n) * DAYS_YEAR;
         quads = (9'(n) + 9'd3) >> 2;
         if (n == 8'd0) begin
            cents = 2'd0;
         end else if (n <= 8'd100) begin
            cents = 2'd1;
         end else if (n <= 8'd200) begin
            cents = 2'd2;
         end else begin
            cents = 2'd3;
         end
         quad_cents = (n != 8'd0);
         days_before = base + 17'(quads) - 17'(cents) + 17'(quad_cents);
      end
   endfunction

   // Cumulative days before month index idx (0 is January).
   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
      begin
         cum_days = leap ? CUM_LEAP[idx] : CUM_NORM[idx];
      end
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/s2cd_sdiv.sv
// Restoring bit-serial divider that retires one quotient bit per cycle while ctrl.step is high.
`timescale 1ns / 1ps
`default_nettype none

module s2cd_sdiv #(
   parameter int DIVIDEND_W = 32,
   parameter int REM_W      = 17
) (
   input  wire                             clock,
   input  wire s2cd_pkg::div_ctrl_type     ctrl,
   input  wire logic [DIVIDEND_W-1:0]      dividend,
   input  wire logic [REM_W-1:0]           divisor,
   output logic      [DIVIDEND_W-1:0]      quotient,
   output logic      [REM_W-1:0]           remainder
);
   import s2cd_pkg::*;

   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [REM_W:0]        trial;
   logic [REM_W:0]        diff;
   logic                  fits;

   // One restoring step: bring in the next dividend bit, subtract when it fits.
   always_comb begin
      trial  = {rem_ff, q_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, divisor};
      fits   = (trial >= {1'b0, divisor});
      q_in   = q_ff;
      rem_in = rem_ff;
      if (ctrl.load) begin
         q_in   = dividend;
         rem_in = '0;
      end else if (ctrl.step) begin
         q_in   = {q_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      end
   end

   // Dividend bits leave at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/seconds_to_calendar_date.sv
// Top level: converts a count of seconds since 2000-01-01 00:00:00 into a calendar date and time.
//
//   Channel  Direction  Word contents (lowest bit first)
//   req_     in         tdata: seconds_count[31:0]
//   rsp_     out        tdata: year[11:0] month[15:12] day[20:16] hour[25:21]
//                              minute[31:26] second[37:32], zero pad [39:38]
//
// One word is in work at a time; req_tready is high only while the converter is free.
// A word is first divided by 86400 and the day count reloaded; then the date path (days
// by 366, removal of whole years, year corrections, month search) and the hour, minute
// and second path run side by side, and the word is handed over once both are done.
// Reset is synchronous and clears the sequencers and the output valid flag.
// A finished word waits in the output register while the next request is taken; the
// hand-over stalls while that register still holds an untaken word.
`timescale 1ns / 1ps
`default_nettype none

module seconds_to_calendar_date #(
   parameter int COUNT_WIDTH = s2cd_pkg::COUNT_WIDTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // seconds_count[31:0]
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic      [39:0]  rsp_tdata    // year, month, day, hour, minute, second, pad
);
   import s2cd_pkg::*;

   localparam int DAYS_W = COUNT_WIDTH - 16;
   localparam int OFF_W  = (DAYS_W > 8) ? DAYS_W - 8 : 1;
   localparam int CNT_W  = $clog2(COUNT_WIDTH + 1);

   // Date sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV1  = 3'd1;
   localparam logic [2:0] S_LD2   = 3'd2;
   localparam logic [2:0] S_DIV2  = 3'd3;
   localparam logic [2:0] S_DBEF  = 3'd4;
   localparam logic [2:0] S_CORR  = 3'd5;
   localparam logic [2:0] S_MONTH = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // Time-of-day sequencer states.
   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_HOUR  = 3'd1;
   localparam logic [2:0] T_LDMIN = 3'd2;
   localparam logic [2:0] T_MIN   = 3'd3;
   localparam logic [2:0] T_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        tstate_ff, tstate_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [4:0]        tcnt_ff, tcnt_in;
   logic [2:0]        guard_ff, guard_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [YN_W-1:0]   yn_ff, yn_in;
   logic [3:0]        month_ff, month_in;
   logic [4:0]        hour_ff, hour_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [39:0]       rsp_data_ff, rsp_data_in;

   div_ctrl_type            a_ctrl, b_ctrl;
   logic [COUNT_WIDTH-1:0]  a_dividend, a_quot;
   logic [DAY_REM_W-1:0]    a_divisor, a_rem;
   logic [DAY_REM_W-1:0]    b_dividend, b_quot;
   logic [TOD_REM_W-1:0]    b_divisor, b_rem;

   logic              leap;
   logic [16:0]       days_ext;
   logic [16:0]       year_len;
   logic [16:0]       days_gone;
   logic [OFF_W-1:0]  off;
   logic [8:0]        cum_next;
   logic [8:0]        cum_this;

   // Day divider: seconds by 86400, then days by 366.
   s2cd_sdiv #(.DIVIDEND_W(COUNT_WIDTH), .REM_W(DAY_REM_W)) u_day_div (
      .clock     (clock),
      .ctrl      (a_ctrl),
      .dividend  (a_dividend),
      .divisor   (a_divisor),
      .quotient  (a_quot),
      .remainder (a_rem)
   );

   // Time-of-day divider: seconds of day by 3600, then by 60.
   s2cd_sdiv #(.DIVIDEND_W(DAY_REM_W), .REM_W(TOD_REM_W)) u_tod_div (
      .clock     (clock),
      .ctrl      (b_ctrl),
      .dividend  (b_dividend),
      .divisor   (b_divisor),
      .quotient  (b_quot),
      .remainder (b_rem)
   );

   assign a_divisor = (state_ff == S_DIV1) ? SECS_PER_DAY : DAYS_LEAP_YEAR;
   assign b_divisor = (tstate_ff == T_HOUR) ? SECS_PER_HOUR : SECS_PER_MIN;

   assign leap     = is_leap(yn_ff);
   assign days_ext = 17'(days_ff);
   assign year_len = DAYS_YEAR + 17'(leap);
   assign off      = a_quot[OFF_W-1:0];
   assign days_gone = days_before(8'(off));
   assign cum_next = cum_days(leap, month_ff + 4'd1);
   assign cum_this = cum_days(leap, month_ff);

   // Date sequencer: day division, year estimate and correction, month search, result hand-over.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      guard_in   = guard_ff;
      days_in    = days_ff;
      yn_in      = yn_ff;
      month_in   = month_ff;
      a_ctrl     = '0;
      a_dividend = req_tdata[COUNT_WIDTH-1:0];
      tstate_in  = tstate_ff;
      tcnt_in    = tcnt_ff;
      hour_in    = hour_ff;
      b_ctrl     = '0;
      b_dividend = a_rem;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               a_ctrl.load = 1'b1;
               cnt_in      = '0;
               state_in    = S_DIV1;
            end
         end
         S_DIV1: begin
            a_ctrl.step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COUNT_WIDTH - 1)) begin
               state_in = S_LD2;
            end
         end
         S_LD2: begin
            // Days go back into the divider top-aligned; seconds of day go to the other one.
            days_in     = a_quot[DAYS_W-1:0];
            a_ctrl.load = 1'b1;
            a_dividend  = {a_quot[DAYS_W-1:0], {(COUNT_WIDTH - DAYS_W){1'b0}}};
            cnt_in      = '0;
            state_in    = S_DIV2;
            b_ctrl.load = 1'b1;
            tcnt_in     = '0;
            tstate_in   = T_HOUR;
         end
         S_DIV2: begin
            a_ctrl.step = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DAYS_W - 1)) begin
               state_in = S_DBEF;
            end
         end
         S_DBEF: begin
            // Remove the days of all whole years below the first estimate.
            days_in  = DAYS_W'(days_ext - days_gone);
            yn_in    = YN_W'(off);
            guard_in = '0;
            state_in = S_CORR;
         end
         S_CORR: begin
            if (days_ext < year_len) begin
               month_in = '0;
               state_in = S_MONTH;
            end else begin
               days_in = DAYS_W'(days_ext - year_len);
               yn_in   = yn_ff + 1'b1;
               if (guard_ff == 3'd7) begin
                  month_in = '0;
                  state_in = S_MONTH;
               end else begin
                  guard_in = guard_ff + 1'b1;
               end
            end
         end
         S_MONTH: begin
            if ((month_ff < 4'd11) && (days_ext >= 17'(cum_next))) begin
               month_in = month_ff + 1'b1;
            end else begin
               days_in  = DAYS_W'(days_ext - 17'(cum_this));
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if ((tstate_ff == T_DONE) && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, b_rem[5:0], b_quot[5:0], hour_ff,
                               5'(days_ff) + 5'd1, month_ff + 4'd1,
                               EPOCH_YEAR + 12'(yn_ff)};
               state_in     = S_IDLE;
               tstate_in    = T_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Time-of-day sequencer runs beside the date search.
      case (tstate_ff)
         T_IDLE: begin
         end
         T_HOUR: begin
            b_ctrl.step = 1'b1;
            tcnt_in     = tcnt_ff + 1'b1;
            if (tcnt_ff == 5'(DAY_REM_W - 1)) begin
               tstate_in = T_LDMIN;
            end
         end
         T_LDMIN: begin
            hour_in     = b_quot[4:0];
            b_ctrl.load = 1'b1;
            b_dividend  = {b_rem, {(DAY_REM_W - TOD_REM_W){1'b0}}};
            tcnt_in     = '0;
            tstate_in   = T_MIN;
         end
         T_MIN: begin
            b_ctrl.step = 1'b1;
            tcnt_in     = tcnt_ff + 1'b1;
            if (tcnt_ff == 5'(TOD_REM_W - 1)) begin
               tstate_in = T_DONE;
            end
         end
         T_DONE: begin
         end
         default: begin
            tstate_in = T_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tstate_ff    <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tstate_ff    <= tstate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output data registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      tcnt_ff     <= tcnt_in;
      guard_ff    <= guard_in;
      days_ff     <= days_in;
      yn_ff       <= yn_in;
      month_ff    <= month_in;
      hour_ff     <= hour_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/s2cd_check.sv
// Port-level checks for the seconds-to-date converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module s2cd_check (
   input wire              clock,
   input wire              reset,
   input wire              req_tvalid,
   input wire              req_tready,
   input wire              rsp_tvalid,
   input wire              rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // A word that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // One word in work at a time: the converter is busy right after an accept.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a conversion is in work");

   // Year and month lie in range, the day is at least 1 and the pad bits are zero.
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:0] >= 12'd2000) && (rsp_tdata[11:0] <= 12'd2136) &&
                     (rsp_tdata[15:12] >= 4'd1) && (rsp_tdata[15:12] <= 4'd12) &&
                     (rsp_tdata[20:16] >= 5'd1) && (rsp_tdata[39:38] == 2'b00))
      else $error("date fields out of range");

   // Time of day lies in range.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[25:21] <= 5'd23) && (rsp_tdata[31:26] <= 6'd59) &&
                     (rsp_tdata[37:32] <= 6'd59))
      else $error("time fields out of range");

endmodule

bind seconds_to_calendar_date s2cd_check u_s2cd_check (.*);

`default_nettype wire
